// ===== rtl/wmmt_pkg.sv =====
// Shared types and constants of the weekly min/max/mean tracker.
package wmmt_pkg;

  localparam int SampleW    = 16;
  localparam int ActW       = 8;
  localparam int DayIdxW    = 3;
  localparam int SlotActW   = 24;
  localparam int SumW       = 40;
  localparam int CntW       = 24;
  localparam int WActW      = 27;
  localparam int MeanW      = 16;
  localparam int QueueDepth = 2;

  // How a request acts on its day slot.
  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_NEW,
    KIND_SAME
  } kind_e;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [ActW-1:0]           activity;
    logic [DayIdxW-1:0]        day;
    kind_e                     kind;
  } cmd_t;

  typedef struct packed {
    logic signed [SampleW-1:0] min_val;
    logic signed [SampleW-1:0] max_val;
    logic [SlotActW-1:0]       act;
    logic signed [SumW-1:0]    sum;
    logic [CntW-1:0]           cnt;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_READ,
    ST_UPDATE,
    ST_SWEEP,
    ST_ABS,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/wmmt_if.sv =====
// Request and result channel interfaces of the tracker.
interface wmmt_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [wmmt_pkg::SampleW-1:0] sample;
  logic [wmmt_pkg::ActW-1:0]          activity;
  logic [wmmt_pkg::DayIdxW-1:0]       day_index;

  modport source (output valid, sample, activity, day_index, input ready);
  modport sink   (input valid, sample, activity, day_index, output ready);
endinterface

interface wmmt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [wmmt_pkg::SampleW-1:0] week_min;
  logic signed [wmmt_pkg::SampleW-1:0] week_max;
  logic signed [wmmt_pkg::MeanW-1:0]   week_mean;
  logic [wmmt_pkg::WActW-1:0]          week_activity;

  modport source (output valid, week_min, week_max, week_mean, week_activity, input ready);
  modport sink   (input valid, week_min, week_max, week_mean, week_activity, output ready);
endinterface

// ===== rtl/weekly_min_max_mean_tracker_top.sv =====
// Weekly min/max/mean tracker: per-day slots over a ring of NUM_DAYS days.
// Each request (sample, activity, day index) updates its day slot and yields
// one result: week minimum, maximum, mean truncated toward zero, and the
// saturated activity total. The very first request seeds every slot. The
// time of a request is set by the one-slot-per-cycle sweep of the slot
// memory and the 16-step shift-subtract divider for the mean. A two-entry
// request queue and an output register let the input side keep accepting
// while a result waits to be taken.
module weekly_min_max_mean_tracker_top #(
  parameter int NUM_DAYS = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wmmt_in_if.sink    req_i,
  wmmt_out_if.source rsp_o
);

  logic           push;
  logic           full;
  logic           q_valid;
  logic           pop;
  wmmt_pkg::cmd_t push_cmd;
  wmmt_pkg::cmd_t pop_cmd;

  wmmt_front #(
    .NUM_DAYS (NUM_DAYS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  wmmt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (pop_cmd)
  );

  wmmt_back #(
    .NUM_DAYS (NUM_DAYS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (pop),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== rtl/wmmt_front.sv =====
// Front end: takes requests, wraps the day index and classifies each request.
module wmmt_front #(
  parameter int NUM_DAYS = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wmmt_in_if.sink           req_i,
  input  logic              full_i,
  output logic              push_o,
  output wmmt_pkg::cmd_t    cmd_o
);

  localparam int WrapW = wmmt_pkg::DayIdxW + 2;

  logic                             started_q, started_d;
  logic [wmmt_pkg::DayIdxW-1:0]     cur_day_q, cur_day_d;
  logic [wmmt_pkg::DayIdxW-1:0]     day;

  // Day index modulo NUM_DAYS by repeated subtraction on a narrow value.
  function automatic logic [wmmt_pkg::DayIdxW-1:0] day_wrap(
    input logic [wmmt_pkg::DayIdxW-1:0] v
  );
    logic [WrapW-1:0] r;
    r = WrapW'(v);
    for (int i = 0; i < (1 << wmmt_pkg::DayIdxW); i++) begin
      if (r >= WrapW'(NUM_DAYS)) begin
        r = r - WrapW'(NUM_DAYS);
      end
    end
    return r[wmmt_pkg::DayIdxW-1:0];
  endfunction

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;
  assign day         = day_wrap(req_i.day_index);

  always_comb begin
    cmd_o.sample   = req_i.sample;
    cmd_o.activity = req_i.activity;
    cmd_o.day      = day;
    if (!started_q) begin
      cmd_o.kind = wmmt_pkg::KIND_FIRST;
    end else if (cur_day_q != day) begin
      cmd_o.kind = wmmt_pkg::KIND_NEW;
    end else begin
      cmd_o.kind = wmmt_pkg::KIND_SAME;
    end
  end

  always_comb begin
    started_d = started_q;
    cur_day_d = cur_day_q;
    if (push_o) begin
      started_d = 1'b1;
      cur_day_d = day;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      cur_day_q <= '0;
    end else begin
      started_q <= started_d;
      cur_day_q <= cur_day_d;
    end
  end

endmodule

// ===== rtl/wmmt_queue.sv =====
// Short request queue between the front end and the slot engine.
module wmmt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wmmt_pkg::cmd_t data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output wmmt_pkg::cmd_t data_o
);

  localparam int PtrW = $clog2(wmmt_pkg::QueueDepth);
  localparam int CntW = $clog2(wmmt_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(wmmt_pkg::QueueDepth - 1);

  wmmt_pkg::cmd_t    store_q [wmmt_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(wmmt_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/wmmt_back.sv =====
// Slot engine: updates the day slot memory, sweeps it and divides for the mean.
module wmmt_back #(
  parameter int NUM_DAYS = 7
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  wmmt_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  wmmt_out_if.source     rsp_o
);

  localparam int DayW  = $clog2(NUM_DAYS);
  localparam int IdxW  = $clog2(NUM_DAYS + 1);
  localparam int TCntW = wmmt_pkg::CntW + $clog2(NUM_DAYS);
  localparam int TSumW = wmmt_pkg::SumW + $clog2(NUM_DAYS);
  localparam int RemW  = TCntW + 1;
  localparam int StepW = $clog2(wmmt_pkg::MeanW);
  localparam int SW    = wmmt_pkg::SampleW;
  localparam int AW    = wmmt_pkg::SlotActW;
  localparam int WW    = wmmt_pkg::WActW;

  localparam logic [IdxW-1:0]  LastSeed  = IdxW'(NUM_DAYS - 1);
  localparam logic [IdxW-1:0]  LastSweep = IdxW'(NUM_DAYS);
  localparam logic [StepW-1:0] LastStep  = StepW'(wmmt_pkg::MeanW - 1);
  localparam logic signed [SW-1:0] MinInit = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] MaxInit = {1'b1, {(SW-1){1'b0}}};

  wmmt_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [StepW-1:0] step_q, step_d;

  wmmt_pkg::cmd_t   cmd_q;
  wmmt_pkg::slot_t  mem [NUM_DAYS];
  wmmt_pkg::slot_t  rd_q;

  logic signed [SW-1:0]    wmin_q, wmax_q;
  logic signed [TSumW-1:0] tsum_q;
  logic [TCntW-1:0]        tcnt_q;
  logic [WW-1:0]           wact_q;
  logic                    neg_q;
  logic [RemW-1:0]         rem_q;
  logic [wmmt_pkg::MeanW-1:0] quo_q;

  logic                    out_valid_q;
  logic signed [SW-1:0]    res_min_q, res_max_q;
  logic signed [wmmt_pkg::MeanW-1:0] res_mean_q;
  logic [WW-1:0]           res_act_q;

  logic                    mem_we;
  logic [DayW-1:0]         mem_waddr, mem_raddr;
  wmmt_pkg::slot_t         mem_wdata;
  logic [DayW+wmmt_pkg::DayIdxW-1:0] day_ext;
  logic [DayW-1:0]         day_addr;
  logic                    out_free;

  wmmt_pkg::slot_t         restart_slot, seed_slot, merge_slot;
  logic [AW:0]             act_sum;
  logic [WW:0]             wact_sum;
  logic [TSumW-1:0]        mag;
  logic [RemW-1:0]         trial;
  logic                    ge;
  logic [wmmt_pkg::MeanW-1:0] mean_mag;

  assign day_ext  = {{DayW{1'b0}}, cmd_q.day};
  assign day_addr = day_ext[DayW-1:0];
  assign out_free = !out_valid_q || rsp_o.ready;

  // Slot contents for the three kinds of write.
  always_comb begin
    restart_slot.min_val = cmd_q.sample;
    restart_slot.max_val = cmd_q.sample;
    restart_slot.act     = AW'(cmd_q.activity);
    restart_slot.sum     = wmmt_pkg::SumW'($signed(cmd_q.sample));
    restart_slot.cnt     = wmmt_pkg::CntW'(1);

    seed_slot.min_val = cmd_q.sample;
    seed_slot.max_val = cmd_q.sample;
    seed_slot.act     = '0;
    seed_slot.sum     = '0;
    seed_slot.cnt     = '0;

    act_sum = {1'b0, rd_q.act} + (AW+1)'(cmd_q.activity);
    merge_slot.min_val = ($signed(cmd_q.sample) < $signed(rd_q.min_val)) ?
                         cmd_q.sample : rd_q.min_val;
    merge_slot.max_val = ($signed(cmd_q.sample) > $signed(rd_q.max_val)) ?
                         cmd_q.sample : rd_q.max_val;
    merge_slot.act     = act_sum[AW] ? '1 : act_sum[AW-1:0];
    if (rd_q.cnt != '1) begin
      merge_slot.sum = rd_q.sum + wmmt_pkg::SumW'($signed(cmd_q.sample));
      merge_slot.cnt = rd_q.cnt + 1'b1;
    end else begin
      merge_slot.sum = rd_q.sum;
      merge_slot.cnt = rd_q.cnt;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      wmmt_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.kind == wmmt_pkg::KIND_FIRST) ? wmmt_pkg::ST_SEED
                                                          : wmmt_pkg::ST_READ;
        end
      end
      wmmt_pkg::ST_SEED: begin
        if (idx_q == LastSeed) state_d = wmmt_pkg::ST_SWEEP;
      end
      wmmt_pkg::ST_READ:   state_d = wmmt_pkg::ST_UPDATE;
      wmmt_pkg::ST_UPDATE: state_d = wmmt_pkg::ST_SWEEP;
      wmmt_pkg::ST_SWEEP: begin
        if (idx_q == LastSweep) state_d = wmmt_pkg::ST_ABS;
      end
      wmmt_pkg::ST_ABS:    state_d = wmmt_pkg::ST_DIV;
      wmmt_pkg::ST_DIV: begin
        if (step_q == LastStep) state_d = wmmt_pkg::ST_DONE;
      end
      wmmt_pkg::ST_DONE: begin
        if (out_free) state_d = wmmt_pkg::ST_IDLE;
      end
      default: state_d = wmmt_pkg::ST_IDLE;
    endcase
  end

  // Outputs and counters.
  always_comb begin
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = day_addr;
    mem_wdata = restart_slot;
    mem_raddr = day_addr;
    idx_d     = '0;
    step_d    = '0;
    case (state_q)
      wmmt_pkg::ST_IDLE: cmd_pop_o = cmd_valid_i;
      wmmt_pkg::ST_SEED: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[DayW-1:0];
        mem_wdata = (idx_q[DayW-1:0] == day_addr) ? restart_slot : seed_slot;
        idx_d     = (idx_q == LastSeed) ? '0 : idx_q + 1'b1;
      end
      wmmt_pkg::ST_UPDATE: begin
        mem_we    = 1'b1;
        mem_wdata = (cmd_q.kind == wmmt_pkg::KIND_SAME) ? merge_slot : restart_slot;
      end
      wmmt_pkg::ST_SWEEP: begin
        mem_raddr = idx_q[DayW-1:0];
        idx_d     = (idx_q == LastSweep) ? '0 : idx_q + 1'b1;
      end
      wmmt_pkg::ST_DIV: step_d = (step_q == LastStep) ? '0 : step_q + 1'b1;
      default: ;
    endcase
  end

  // Arithmetic of the sweep, the magnitude and sign of the mean, and one divider step.
  always_comb begin
    wact_sum = {1'b0, wact_q} + (WW+1)'(rd_q.act);
    mag      = tsum_q[TSumW-1] ? $unsigned(-tsum_q) : $unsigned(tsum_q);
    trial    = {rem_q[TCntW-1:0], quo_q[wmmt_pkg::MeanW-1]};
    ge       = (trial >= {1'b0, tcnt_q});
    mean_mag = neg_q ? (~quo_q + 1'b1) : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wmmt_pkg::ST_IDLE;
      idx_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
      if (state_q == wmmt_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[mem_raddr];

    case (state_q)
      wmmt_pkg::ST_SWEEP: begin
        // Read data is registered, so it trails the sweep address.
        if (idx_q == '0) begin
          wmin_q <= MinInit;
          wmax_q <= MaxInit;
          tsum_q <= '0;
          tcnt_q <= '0;
          wact_q <= '0;
        end else begin
          if ($signed(rd_q.min_val) < wmin_q) wmin_q <= rd_q.min_val;
          if ($signed(rd_q.max_val) > wmax_q) wmax_q <= rd_q.max_val;
          tsum_q <= tsum_q + TSumW'($signed(rd_q.sum));
          tcnt_q <= tcnt_q + TCntW'(rd_q.cnt);
          wact_q <= wact_sum[WW] ? '1 : wact_sum[WW-1:0];
        end
      end
      wmmt_pkg::ST_ABS: begin
        // Quotient fits 16 bits, so the upper part starts below the divisor.
        neg_q <= tsum_q[TSumW-1];
        rem_q <= RemW'(mag >> wmmt_pkg::MeanW);
        quo_q <= mag[wmmt_pkg::MeanW-1:0];
      end
      wmmt_pkg::ST_DIV: begin
        rem_q <= ge ? (trial - {1'b0, tcnt_q}) : trial;
        quo_q <= {quo_q[wmmt_pkg::MeanW-2:0], ge};
      end
      default: ;
    endcase

    if (state_q == wmmt_pkg::ST_DONE && out_free) begin
      res_min_q  <= wmin_q;
      res_max_q  <= wmax_q;
      res_mean_q <= (tcnt_q == '0) ? '0 : mean_mag;
      res_act_q  <= wact_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.week_min      = res_min_q;
  assign rsp_o.week_max      = res_max_q;
  assign rsp_o.week_mean     = res_mean_q;
  assign rsp_o.week_activity = res_act_q;

endmodule
